// ===== design/hvct_pkg.sv =====
// Shared types and constants for the hash versus compact target checker.
`default_nettype none

package hvct_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned MANT_W     = 24;
    localparam int unsigned EXP_W      = 8;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned IDX_W      = 2;
    localparam int unsigned ORDER_W    = 2;

    localparam logic [EXP_W-1:0] EXP_MAX    = 8'd32;
    localparam logic [EXP_W-1:0] MANT_BYTES = 8'd3;

    localparam logic [CFG_W-1:0] COMPACT_RESET = 32'h1D00_FFFF;

    localparam logic [ORDER_W-1:0] ORDER_BELOW = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_ABOVE = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] hash_word;
        logic              word_last;
    } t_in_beat;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic               meets_target;
        logic               invalid_target;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== design/hvct_target_slice.sv =====
// Decode one 64-bit slice of the target from its compact form.
`default_nettype none

module hvct_target_slice (
    input  wire logic [hvct_pkg::CFG_W-1:0]  i_compact_target,
    input  wire logic [hvct_pkg::IDX_W-1:0]  i_word_index,
    output logic      [hvct_pkg::WORD_W-1:0] o_slice
);
    import hvct_pkg::*;

    logic [EXP_W-1:0]   expo;
    logic [WORD_W-1:0]  mant_wide;
    logic [4:0]         small_shift;
    logic signed [11:0] offset;
    logic signed [11:0] neg_offset;

    assign expo      = i_compact_target[CFG_W-1:MANT_W];
    assign mant_wide = {{(WORD_W-MANT_W){1'b0}}, i_compact_target[MANT_W-1:0]};

    // Number of bits dropped from the mantissa when the exponent is 3 or less.
    assign small_shift = {2'(MANT_BYTES[1:0] - expo[1:0]), 3'b000};

    // Bit offset of the mantissa relative to the base of the selected slice.
    assign offset = $signed({1'b0, expo, 3'b000})
                  - $signed({1'b0, MANT_BYTES, 3'b000})
                  - $signed({4'b0000, i_word_index, 6'b000000});
    assign neg_offset = -offset;

    always_comb begin
        o_slice = '0;
        if (expo <= MANT_BYTES) begin
            if (i_word_index == '0) begin
                o_slice = mant_wide >> small_shift;
            end
        end else if (offset >= 12'sd0) begin
            if (offset < 12'sd64) begin
                o_slice = mant_wide << offset[5:0];
            end
        end else begin
            if (neg_offset < 12'sd64) begin
                o_slice = mant_wide >> neg_offset[5:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hash_vs_compact_target_check_unit.sv =====
// Top level: compare a streamed 256-bit hash against a compact target.
//
//  channel  | handshake                 | payload                      | dir
//  ---------+---------------------------+------------------------------+-----
//  in       | i_in_valid / o_in_ready   | i_in_beat  (hash_word, last) | in
//  out      | o_out_valid / i_out_ready | o_out_beat (order, flags)    | out
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_data (compact target)  | in
//
// One hash word per cycle, except in the stall described below. A word is held
// in the input register, where its target slice is decoded and compared; the
// result of a last word is then registered in the output register. The only
// stall is a full output register that is not being drained when a last word
// wants to move into it; non-last words never wait on the output side. Reset
// is synchronous and active low; it clears the valid flags, the word index,
// the running order, and loads the default compact target. The config port
// is always ready.
`default_nettype none

module hash_vs_compact_target_check_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire hvct_pkg::t_in_beat         i_in_beat,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output hvct_pkg::t_out_beat             o_out_beat,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [hvct_pkg::CFG_W-1:0] i_cfg_data
);
    import hvct_pkg::*;

    // Configuration register.
    logic [CFG_W-1:0]   r_compact_target;

    // Input stage.
    logic               r_in_valid;
    t_in_beat           r_in;

    // Running state across the words of one hash.
    logic [IDX_W-1:0]   r_word_index;
    logic [ORDER_W-1:0] r_running_order;
    logic [IDX_W-1:0]   n_word_index;
    logic [ORDER_W-1:0] n_running_order;

    // Output stage.
    logic               r_out_valid;
    t_out_beat          r_out;
    t_out_beat          n_out;

    logic [WORD_W-1:0]  slice;
    logic               invalid;
    logic               out_free;
    logic               s1_go;
    logic [ORDER_W-1:0] word_order;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compact_target <= COMPACT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_compact_target <= i_cfg_data;
        end
    end

    // Advance the input stage unless a last word would hit a full output.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_in_valid && (!r_in.word_last || out_free);
    assign o_in_ready = !r_in_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload: no reset needed, capture on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_beat;
        end
    end

    hvct_target_slice u_slice (
        .i_compact_target (r_compact_target),
        .i_word_index     (r_word_index),
        .o_slice          (slice)
    );

    assign invalid = r_compact_target[CFG_W-1:MANT_W] > EXP_MAX;

    // A differing word overrides whatever the less significant words said.
    always_comb begin
        word_order = r_running_order;
        if (!invalid) begin
            if (r_in.hash_word > slice) begin
                word_order = ORDER_ABOVE;
            end else if (r_in.hash_word < slice) begin
                word_order = ORDER_BELOW;
            end
        end
    end

    always_comb begin
        n_word_index    = r_word_index;
        n_running_order = r_running_order;
        n_out           = r_out;
        if (s1_go) begin
            if (r_in.word_last) begin
                // Emit and drop back to the start of a new hash.
                n_word_index    = '0;
                n_running_order = ORDER_EQUAL;
                if (invalid) begin
                    n_out.order          = ORDER_BELOW;
                    n_out.meets_target   = 1'b0;
                    n_out.invalid_target = 1'b1;
                end else begin
                    n_out.order          = word_order;
                    n_out.meets_target   = (word_order != ORDER_ABOVE);
                    n_out.invalid_target = 1'b0;
                end
            end else begin
                // Long hashes wrap the index and keep comparing.
                n_word_index    = IDX_W'(r_word_index + 1'b1);
                n_running_order = word_order;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index    <= '0;
            r_running_order <= ORDER_EQUAL;
            r_out_valid     <= 1'b0;
        end else begin
            r_word_index    <= n_word_index;
            r_running_order <= n_running_order;
            if (s1_go && r_in.word_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef SYNTH
    a_invalid_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.invalid_target)
            |-> (o_out_beat.order == ORDER_BELOW && !o_out_beat.meets_target))
        else $error("invalid target result carries non-zero fields");

    a_meets_matches_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.invalid_target)
            |-> (o_out_beat.meets_target == (o_out_beat.order != ORDER_ABOVE)))
        else $error("meets_target disagrees with order");

    a_last_restarts_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_in.word_last)
            |=> (r_word_index == '0 && r_running_order == ORDER_EQUAL && o_out_valid))
        else $error("state not restarted after a last word");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in.word_last && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked output");
`endif

endmodule

`default_nettype wire
